FILE: hw/rtl/pact_pkg.sv
// Package for the probe/association correlation table.
// Holds the request and event codes, the table entry layout and the sequencer states.
// No dependencies.
package pact_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int MAC_W             = 48;
    localparam int HANDLE_W          = 16;
    localparam int AGE_W             = 17;
    localparam int MAX_AGE_W         = 16;
    localparam int REQ_W             = 3;
    localparam int KIND_W            = 2;
    localparam int APB_ADDR_W        = 3;
    localparam int APB_DATA_W        = 32;

    localparam logic [AGE_W-1:0]     AGE_SAT         = '1;
    localparam logic [MAX_AGE_W-1:0] MAX_AGE_RESET   = 16'd64;

    localparam logic [REQ_W-1:0] REQ_PROBE     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PROBE_RSP = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ASSOC     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ASSOC_RSP = 3'd3;
    localparam logic [REQ_W-1:0] REQ_AUTH      = 3'd4;
    localparam logic [REQ_W-1:0] REQ_DEAUTH    = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNHANDLED = 3'd6;

    localparam logic [KIND_W-1:0] EV_FORWARD = 2'd0;
    localparam logic [KIND_W-1:0] EV_STALE   = 2'd1;
    localparam logic [KIND_W-1:0] EV_DROP    = 2'd2;

    localparam logic REG_MAX_AGE = 1'b0;
    localparam logic REG_FWD_EN  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_PLACE,
        ST_REQ,
        ST_FLUSH
    } pact_state_t;

    typedef struct packed {
        logic [MAC_W-1:0]    mac;
        logic [HANDLE_W-1:0] handle;
        logic [AGE_W-1:0]    age;
    } pact_entry_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [MAC_W-1:0]    mac;
        logic [HANDLE_W-1:0] handle;
        logic [AGE_W-1:0]    age;
    } pact_event_t;

endpackage

FILE: hw/rtl/probe_assoc_correlation_table_unit.sv
// Top level of the probe/association correlation table.
// Depends on pact_pkg for codes, entry layout and sequencer states.
//
// One request at a time: a probe request walks every table entry through one
// shared age/compare unit, each entry read from memory and then evaluated and
// written back, after the accepting cycle; a place state then inserts a new MAC
// or drops it when the table is full, and a flush state releases the final event
// before the next request is accepted. An association request walks entries
// until its MAC is found, at most all of them; an authentication request passes
// through the request and flush states; other types stay idle. Each event waits
// in a one-deep hold stage so that the last flag is known, then goes to the
// output register; a stalled output holds the walk. Entry contents sit in a
// single-port memory with registered read; only the valid bits are flip-flops,
// cleared at reset, so no clearing pass is needed.
module probe_assoc_correlation_table_unit
    import pact_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [REQ_W-1:0]      req_type,
    input  logic [MAC_W-1:0]      src_mac,
    input  logic [HANDLE_W-1:0]   frame_handle,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [KIND_W-1:0]     event_kind,
    output logic [MAC_W-1:0]      event_mac,
    output logic [HANDLE_W-1:0]   event_handle,
    output logic [AGE_W-1:0]      event_age,
    output logic                  last
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

    pact_state_t state_reg, state_next;

    logic [MAX_AGE_W-1:0]     max_age_reg;
    logic                     fwd_en_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;

    logic [REQ_W-1:0]    type_reg;
    logic [MAC_W-1:0]    mac_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                hit_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    free_idx_reg;

    pact_entry_t mem [TABLE_ENTRIES];
    pact_entry_t rdata_reg;

    logic        pend_valid_reg;
    pact_event_t pend_reg;
    logic        out_valid_reg;
    pact_event_t out_reg;
    logic        out_last_reg;

    logic             in_accept;
    logic             cfg_write;
    logic             is_probe;
    logic             cur_valid;
    logic             mac_hit;
    logic [AGE_W-1:0] age_inc;
    logic             stale;
    logic             idx_last;
    logic             out_free;
    logic             go;
    logic             push;

    logic             emit_req;
    pact_event_t      emit_ev;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    pact_entry_t      wr_data;
    logic             clr_valid;
    logic             set_valid;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        case (paddr[2])
            REG_MAX_AGE: prdata = {{(APB_DATA_W-MAX_AGE_W){1'b0}}, max_age_reg};
            REG_FWD_EN:  prdata = {{(APB_DATA_W-1){1'b0}}, fwd_en_reg};
            default:     prdata = '0;
        endcase
    end

    assign is_probe  = (type_reg == REQ_PROBE);
    assign cur_valid = valid_reg[idx_reg];
    assign mac_hit   = cur_valid && (rdata_reg.mac == mac_reg);
    assign age_inc   = (rdata_reg.age == AGE_SAT) ? rdata_reg.age : rdata_reg.age + AGE_W'(1);
    assign stale     = age_inc > {1'b0, max_age_reg};
    assign idx_last  = (idx_reg == IDX_LAST);
    assign out_free  = !out_valid_reg || out_ready;

    // sequencer actions
    always_comb
    begin
        emit_req  = 1'b0;
        emit_ev   = '0;
        wr_en     = 1'b0;
        wr_addr   = idx_reg;
        wr_data   = rdata_reg;
        clr_valid = 1'b0;
        set_valid = 1'b0;
        case (state_reg)
            ST_EVAL:
            begin
                if (is_probe)
                begin
                    if (cur_valid)
                    begin
                        if (stale)
                        begin
                            emit_req  = 1'b1;
                            emit_ev   = '{EV_STALE, rdata_reg.mac, rdata_reg.handle, age_inc};
                            clr_valid = 1'b1;
                        end
                        else
                        begin
                            wr_en          = 1'b1;
                            wr_data.age    = age_inc;
                            wr_data.handle = mac_hit ? handle_reg : rdata_reg.handle;
                        end
                    end
                end
                else if (mac_hit)
                begin
                    clr_valid = 1'b1;
                    emit_req  = fwd_en_reg;
                    emit_ev   = '{EV_FORWARD, rdata_reg.mac, rdata_reg.handle, '0};
                end
            end
            ST_PLACE:
            begin
                if (!hit_reg)
                begin
                    if (free_found_reg)
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = free_idx_reg;
                        wr_data   = '{mac_reg, handle_reg, '0};
                        set_valid = 1'b1;
                    end
                    else
                    begin
                        emit_req = 1'b1;
                        emit_ev  = '{EV_DROP, mac_reg, handle_reg, '0};
                    end
                end
            end
            ST_REQ:
            begin
                emit_req = fwd_en_reg;
                emit_ev  = '{EV_FORWARD, mac_reg, handle_reg, '0};
            end
            default:
            begin
                emit_req = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == ST_FLUSH)
        begin
            go   = !pend_valid_reg || out_free;
            push = pend_valid_reg && out_free;
        end
        else
        begin
            go   = !emit_req || !pend_valid_reg || out_free;
            push = emit_req && pend_valid_reg && out_free;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == REQ_PROBE || req_type == REQ_ASSOC)
                        state_next = ST_READ;
                    else if (req_type == REQ_AUTH)
                        state_next = ST_REQ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (go)
                begin
                    if (!is_probe && mac_hit)
                        state_next = ST_REQ;
                    else if (idx_last)
                        state_next = is_probe ? ST_PLACE : ST_REQ;
                    else
                        state_next = ST_READ;
                end
            end
            ST_PLACE:
            begin
                if (go)
                    state_next = ST_FLUSH;
            end
            ST_REQ:
            begin
                if (go)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                if (go)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            max_age_reg    <= MAX_AGE_RESET;
            fwd_en_reg     <= 1'b1;
            valid_reg      <= '0;
            idx_reg        <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                case (paddr[2])
                    REG_MAX_AGE: max_age_reg <= pwdata[MAX_AGE_W-1:0];
                    REG_FWD_EN:  fwd_en_reg  <= pwdata[0];
                    default:     max_age_reg <= max_age_reg;
                endcase
            end

            if (in_accept)
            begin
                idx_reg        <= '0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
            end

            if (go)
            begin
                if (clr_valid)
                    valid_reg[idx_reg] <= 1'b0;
                if (set_valid)
                    valid_reg[free_idx_reg] <= 1'b1;
                if (state_reg == ST_EVAL)
                begin
                    if (!idx_last)
                        idx_reg <= idx_reg + IDX_W'(1);
                    if (is_probe)
                    begin
                        if (cur_valid && !stale && mac_hit)
                            hit_reg <= 1'b1;
                        if ((!cur_valid || stale) && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= idx_reg;
                        end
                    end
                end
                if (emit_req)
                    pend_valid_reg <= 1'b1;
                else if (state_reg == ST_FLUSH)
                    pend_valid_reg <= 1'b0;
            end

            if (push)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            type_reg   <= req_type;
            mac_reg    <= src_mac;
            handle_reg <= frame_handle;
        end
        if (go && emit_req)
            pend_reg <= emit_ev;
        if (push)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= (state_reg == ST_FLUSH);
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && wr_en)
            mem[wr_addr] <= wr_data;
        if (state_reg == ST_READ)
            rdata_reg <= mem[idx_reg];
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = out_reg.kind;
    assign event_mac    = out_reg.mac;
    assign event_handle = out_reg.handle;
    assign event_age    = out_reg.age;
    assign last         = out_last_reg;

endmodule

FILE: tb/sv/tb_top.sv
// Testbench for the probe/association correlation table: directed requests, then
// randomized station sequences checked against a table predictor held here.
// Depends on pact_pkg and probe_assoc_correlation_table_unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pact_pkg::*;

    localparam int ENTRIES       = TABLE_ENTRIES_DEF;
    localparam int POOL          = 24;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 50;
    localparam int SETTLE_CYCLES = 2 * ENTRIES + 16;
    localparam int LIMIT_NS      = 5_000_000;

    localparam logic [REQ_W-1:0]      REQ_RESERVED = 3'd7;
    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_AGE = {REG_MAX_AGE, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_FWD_EN  = {REG_FWD_EN, 2'b00};
    localparam logic [MAC_W-1:0]      MAC_ONES     = '1;
    localparam logic [HANDLE_W-1:0]   HANDLE_ONES  = '1;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [MAC_W-1:0]    mac;
        logic [HANDLE_W-1:0] handle;
        logic [AGE_W-1:0]    age;
        logic                last;
    } frame_event_t;

    typedef enum {ROW_REQ, ROW_CFG} row_kind_t;
    typedef enum {BY_MODEL, NO_EVENT, ONE_EVENT} row_check_t;

    typedef struct {
        row_kind_t             op;
        logic [REQ_W-1:0]      req;
        logic [MAC_W-1:0]      mac;
        logic [HANDLE_W-1:0]   hdl;
        row_check_t            chk;
        frame_event_t          ev;
        logic [APB_ADDR_W-1:0] addr;
        logic [APB_DATA_W-1:0] data;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_ready;
    logic [REQ_W-1:0]      req_type;
    logic [MAC_W-1:0]      src_mac;
    logic [HANDLE_W-1:0]   frame_handle;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [KIND_W-1:0]     event_kind;
    logic [MAC_W-1:0]      event_mac;
    logic [HANDLE_W-1:0]   event_handle;
    logic [AGE_W-1:0]      event_age;
    logic                  last;

    logic                  tbl_used[ENTRIES];
    logic [MAC_W-1:0]      tbl_mac[ENTRIES];
    logic [HANDLE_W-1:0]   tbl_handle[ENTRIES];
    logic [AGE_W-1:0]      tbl_age[ENTRIES];
    logic [MAX_AGE_W-1:0]  cfg_max_age;
    logic                  cfg_fwd;

    frame_event_t          due_events[$];
    plan_row_t             plan[$];
    logic [MAC_W-1:0]      mac_pool[POOL];
    int                    errors = 0;
    int                    counted_items = 0;
    bit                    calm = 1'b0;

    probe_assoc_correlation_table_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .src_mac      (src_mac),
        .frame_handle (frame_handle),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_kind   (event_kind),
        .event_mac    (event_mac),
        .event_handle (event_handle),
        .event_age    (event_age),
        .last         (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic frame_event_t mk_event(input logic [KIND_W-1:0] kind,
                                              input logic [MAC_W-1:0] mac,
                                              input logic [HANDLE_W-1:0] hdl,
                                              input logic [AGE_W-1:0] age,
                                              input logic fin);
        frame_event_t e;
        e.kind   = kind;
        e.mac    = mac;
        e.handle = hdl;
        e.age    = age;
        e.last   = fin;
        return e;
    endfunction

    function automatic plan_row_t req_row(input logic [REQ_W-1:0] req,
                                          input logic [MAC_W-1:0] mac,
                                          input logic [HANDLE_W-1:0] hdl,
                                          input row_check_t chk,
                                          input frame_event_t ev);
        plan_row_t r;
        r.op   = ROW_REQ;
        r.req  = req;
        r.mac  = mac;
        r.hdl  = hdl;
        r.chk  = chk;
        r.ev   = ev;
        r.addr = '0;
        r.data = '0;
        return r;
    endfunction

    function automatic plan_row_t cfg_row(input logic [APB_ADDR_W-1:0] addr,
                                          input logic [APB_DATA_W-1:0] data);
        plan_row_t r;
        r      = req_row(REQ_UNHANDLED, '0, '0, NO_EVENT, '0);
        r.op   = ROW_CFG;
        r.addr = addr;
        r.data = data;
        return r;
    endfunction

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[MAC_W-1:0];
    endfunction

    function automatic logic [HANDLE_W-1:0] rand_handle();
        return HANDLE_W'($urandom_range(0, 65535));
    endfunction

    function automatic int find_entry(input logic [MAC_W-1:0] mac);
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_used[i] && tbl_mac[i] == mac)
                return i;
        return -1;
    endfunction

    function automatic void correlate(input logic [REQ_W-1:0] req,
                                      input logic [MAC_W-1:0] mac,
                                      input logic [HANDLE_W-1:0] hdl,
                                      input bit keep);
        frame_event_t evs[$];
        frame_event_t e;
        int hit;
        int slot;
        slot = -1;
        if (req == REQ_PROBE)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (tbl_used[i])
                begin
                    if (tbl_age[i] != AGE_SAT)
                        tbl_age[i] = tbl_age[i] + 1'b1;
                    if (tbl_age[i] > {1'b0, cfg_max_age})
                    begin
                        evs.push_back(mk_event(EV_STALE, tbl_mac[i], tbl_handle[i],
                                               tbl_age[i], 1'b0));
                        tbl_used[i] = 1'b0;
                    end
                end
            end
            hit = find_entry(mac);
            if (hit >= 0)
                tbl_handle[hit] = hdl;
            else
            begin
                for (int i = ENTRIES - 1; i >= 0; i--)
                    if (!tbl_used[i])
                        slot = i;
                if (slot >= 0)
                begin
                    tbl_used[slot]   = 1'b1;
                    tbl_mac[slot]    = mac;
                    tbl_handle[slot] = hdl;
                    tbl_age[slot]    = '0;
                end
                else
                    evs.push_back(mk_event(EV_DROP, mac, hdl, '0, 1'b0));
            end
        end
        else if (req == REQ_ASSOC)
        begin
            hit = find_entry(mac);
            if (hit >= 0)
            begin
                if (cfg_fwd)
                    evs.push_back(mk_event(EV_FORWARD, tbl_mac[hit], tbl_handle[hit],
                                           '0, 1'b0));
                tbl_used[hit] = 1'b0;
            end
            if (cfg_fwd)
                evs.push_back(mk_event(EV_FORWARD, mac, hdl, '0, 1'b0));
        end
        else if (req == REQ_AUTH)
        begin
            if (cfg_fwd)
                evs.push_back(mk_event(EV_FORWARD, mac, hdl, '0, 1'b0));
        end
        if (keep)
        begin
            foreach (evs[i])
            begin
                e      = evs[i];
                e.last = (i == evs.size() - 1);
                due_events.push_back(e);
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic settle(input int extra);
        in_valid <= 1'b0;
        while (due_events.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic program_reg(input logic [APB_ADDR_W-1:0] addr,
                               input logic [APB_DATA_W-1:0] data);
        logic [APB_DATA_W-1:0] mask;
        mask = (addr == ADDR_MAX_AGE) ? 32'h0000_FFFF : 32'h0000_0001;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_MAX_AGE)
            cfg_max_age = data[MAX_AGE_W-1:0];
        else
            cfg_fwd = data[0];
        @(posedge clk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if ((prdata & mask) !== (data & mask))
        begin
            $display("%0t: register %0d read back: expected %h, got %h",
                     $time, addr, data & mask, prdata & mask);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic issue(input logic [REQ_W-1:0] req, input logic [MAC_W-1:0] mac,
                         input logic [HANDLE_W-1:0] hdl, input row_check_t chk,
                         input frame_event_t ev);
        in_valid     <= 1'b1;
        req_type     <= req;
        src_mac      <= mac;
        frame_handle <= hdl;
        do
            @(posedge clk);
        while (!in_ready);
        correlate(req, mac, hdl, chk == BY_MODEL);
        if (chk == ONE_EVENT)
            due_events.push_back(ev);
        if (req == REQ_PROBE || req == REQ_ASSOC || req == REQ_AUTH)
            counted_items++;
        if (!calm && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic run_sequence();
        int pick;
        logic [MAC_W-1:0] mac;
        logic [REQ_W-1:0] rt;
        pick = $urandom_range(0, 99);
        mac  = mac_pool[$urandom_range(0, POOL - 1)];
        if (pick < 50)
        begin
            repeat ($urandom_range(1, 3)) issue(REQ_PROBE, mac, rand_handle(), BY_MODEL, '0);
            if ($urandom_range(0, 1) == 1)
                issue(REQ_AUTH, mac, rand_handle(), BY_MODEL, '0);
            if ($urandom_range(0, 9) < 7)
                issue(REQ_ASSOC, mac, rand_handle(), BY_MODEL, '0);
        end
        else if (pick < 65)
        begin
            repeat ($urandom_range(4, 10))
                issue(REQ_PROBE, mac_pool[$urandom_range(0, POOL - 1)], rand_handle(),
                      BY_MODEL, '0);
        end
        else if (pick < 78)
        begin
            rt = ($urandom_range(0, 1) == 1) ? REQ_ASSOC : REQ_AUTH;
            issue(rt, mac, rand_handle(), BY_MODEL, '0);
        end
        else
        begin
            rt = REQ_W'($urandom_range(0, 7));
            issue(rt, ($urandom_range(0, 1) == 1) ? rand_mac() : mac, rand_handle(),
                  BY_MODEL, '0);
        end
        if ($urandom_range(0, 24) == 0)
            settle(1);
    endtask

    always @(posedge clk)
    begin
        frame_event_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_events.size() == 0)
            begin
                $display("%0t: unexpected event kind=%0d mac=%h handle=%h age=%0d last=%b",
                         $time, event_kind, event_mac, event_handle, event_age, last);
                errors++;
            end
            else
            begin
                want = due_events.pop_front();
                check_field("event_kind", 64'(want.kind), 64'(event_kind));
                check_field("event_mac", 64'(want.mac), 64'(event_mac));
                check_field("event_handle", 64'(want.handle), 64'(event_handle));
                check_field("event_age", 64'(want.age), 64'(event_age));
                check_field("last", 64'(want.last), 64'(last));
            end
        end
        out_ready <= calm || ($urandom_range(0, 99) >= 10);
    end

    initial
    begin
        #LIMIT_NS;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        logic [MAX_AGE_W-1:0] phase_age[PHASES];
        logic                 phase_fwd[PHASES];
        int                   start_items;

        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        in_valid     <= 1'b0;
        req_type     <= '0;
        src_mac      <= '0;
        frame_handle <= '0;
        cfg_max_age = MAX_AGE_RESET;
        cfg_fwd     = 1'b1;
        foreach (tbl_used[i])
            tbl_used[i] = 1'b0;

        plan.push_back(req_row(REQ_AUTH, '0, '0, ONE_EVENT,
                               mk_event(EV_FORWARD, '0, '0, '0, 1'b1)));
        plan.push_back(req_row(REQ_AUTH, MAC_ONES, HANDLE_ONES, ONE_EVENT,
                               mk_event(EV_FORWARD, MAC_ONES, HANDLE_ONES, '0, 1'b1)));
        plan.push_back(req_row(REQ_ASSOC, 48'h1, 16'h8000, ONE_EVENT,
                               mk_event(EV_FORWARD, 48'h1, 16'h8000, '0, 1'b1)));
        plan.push_back(req_row(REQ_PROBE_RSP, 48'hA5A5_A5A5_A5A5, 16'h5A5A, NO_EVENT, '0));
        plan.push_back(req_row(REQ_ASSOC_RSP, 48'h5A5A_5A5A_5A5A, 16'hA5A5, NO_EVENT, '0));
        plan.push_back(req_row(REQ_DEAUTH, MAC_ONES, HANDLE_ONES, NO_EVENT, '0));
        plan.push_back(req_row(REQ_UNHANDLED, 48'h1, 16'h1, NO_EVENT, '0));
        plan.push_back(req_row(REQ_RESERVED, MAC_ONES, 16'h0, NO_EVENT, '0));
        plan.push_back(req_row(REQ_PROBE, MAC_ONES, 16'h0, NO_EVENT, '0));
        plan.push_back(req_row(REQ_PROBE, MAC_ONES, HANDLE_ONES, NO_EVENT, '0));
        plan.push_back(req_row(REQ_ASSOC, MAC_ONES, 16'h1234, BY_MODEL, '0));
        plan.push_back(req_row(REQ_PROBE, 48'hF0, 16'h00F0, NO_EVENT, '0));
        plan.push_back(cfg_row(ADDR_FWD_EN, 32'h0));
        plan.push_back(req_row(REQ_ASSOC, 48'hF0, 16'h0F00, NO_EVENT, '0));
        plan.push_back(req_row(REQ_AUTH, 48'h1, 16'h0001, NO_EVENT, '0));
        plan.push_back(req_row(REQ_ASSOC, 48'hF0, 16'h0F01, NO_EVENT, '0));
        plan.push_back(cfg_row(ADDR_FWD_EN, 32'h1));
        plan.push_back(cfg_row(ADDR_MAX_AGE, 32'h0));
        plan.push_back(req_row(REQ_PROBE, 48'h0B, 16'h000B, NO_EVENT, '0));
        plan.push_back(req_row(REQ_PROBE, 48'h0C, 16'h000C, ONE_EVENT,
                               mk_event(EV_STALE, 48'h0B, 16'h000B, 17'd1, 1'b1)));
        plan.push_back(cfg_row(ADDR_MAX_AGE, 32'h1));
        plan.push_back(req_row(REQ_PROBE, 48'h0D, 16'h000D, BY_MODEL, '0));
        plan.push_back(req_row(REQ_PROBE, 48'h0E, 16'h000E, BY_MODEL, '0));
        plan.push_back(req_row(REQ_PROBE, 48'h0D, 16'hBEEF, BY_MODEL, '0));
        plan.push_back(req_row(REQ_ASSOC, 48'h0E, 16'h4444, BY_MODEL, '0));

        phase_age = '{16'hFFFF, 16'h0, 16'h1, 16'h5, 16'h0, 16'd20};
        phase_fwd = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        phase_age[4] = MAX_AGE_W'($urandom_range(2, 40));
        phase_fwd[4] = 1'($urandom_range(0, 1));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].op == ROW_CFG)
            begin
                settle(SETTLE_CYCLES);
                program_reg(plan[i].addr, plan[i].data);
            end
            else
                issue(plan[i].req, plan[i].mac, plan[i].hdl, plan[i].chk, plan[i].ev);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle(SETTLE_CYCLES);
            program_reg(ADDR_MAX_AGE, APB_DATA_W'(phase_age[ph]));
            program_reg(ADDR_FWD_EN, APB_DATA_W'(phase_fwd[ph]));
            calm = (ph == 1);
            mac_pool[0] = '0;
            mac_pool[1] = MAC_ONES;
            for (int k = 2; k < POOL; k++)
                mac_pool[k] = rand_mac();
            start_items = counted_items;
            // overfill the table first so evictions and drops come early
            for (int k = 0; k < ENTRIES + 2; k++)
                issue(REQ_PROBE, mac_pool[k], rand_handle(), BY_MODEL, '0);
            while (counted_items - start_items < PHASE_ITEMS)
                run_sequence();
        end
        calm = 1'b0;

        settle(SETTLE_CYCLES);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
